>>> src/hcrt_pkg.sv
// Shared types, sizes and codes for the deduplicating record table.
package hcrt_pkg;

  localparam int unsigned Buckets        = 1024;
  localparam int unsigned Records        = 4096;
  localparam int unsigned WordCapacity   = 65536;
  localparam int unsigned MaxRecordWords = 256;

  localparam int unsigned BucketW = $clog2(Buckets);
  localparam int unsigned RecW    = $clog2(Records);
  localparam int unsigned RecPtrW = RecW + 1;
  localparam int unsigned WordW   = $clog2(WordCapacity);
  localparam int unsigned WordCntW = WordW + 1;
  localparam int unsigned StageW  = $clog2(MaxRecordWords);
  localparam int unsigned LenW    = StageW + 1;

  localparam logic [RecPtrW-1:0] NullPtr = RecPtrW'(Records);

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [8:0]  area;
    logic [63:0] word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [11:0] handle;
    status_t     status;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic stage_load;   // capture the input item
    logic hash_init;    // clear hash and index
    logic hash_step;    // fold one staged word
    logic head_read;    // issue bucket head read
    logic head_take;    // take head as current record
    logic meta_read;    // read current record's descriptor
    logic cmp_init;     // start word compare
    logic cmp_step;     // compare one word
    logic chain_adv;    // follow chain_next
    logic ins_meta;     // write descriptor and link
    logic copy_step;    // copy one staged word to the store
    logic finish;       // emit result and clear staging
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_word;
    logic overflow;
    logic hash_done;
    logic chain_end;
    logic meta_match;
    logic cmp_done;
    logic cmp_fail;
    logic full;
    logic copy_done;
    logic steps_over;
    logic clearing;     // bucket heads still being emptied after reset
  } stat_t;

endpackage

>>> src/hash_consing_record_table.sv
// Top level of the deduplicating record table.
//  channel | signals                        | timing
//  input   | start, busy, in_item           | taken when start && !busy
//  output  | result_strobe, result          | one cycle, no stall
// A non-final word holds busy only while the controller checks it, then input is open again.
// A final word holds busy through hashing and the bucket head fetch, then for each
// chain entry through a descriptor read and, when the descriptor matches, a word
// compare; a hit ends after a full compare, an insert writes the descriptor and
// copies the staged words; a finish state follows and the strobe after it.
// After reset the bucket heads are emptied one per cycle, busy high.
// Results cannot be held off by the receiver.
module hash_consing_record_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hcrt_pkg::in_item_t  in_item,
  output logic                result_strobe,
  output hcrt_pkg::out_item_t result
);

  hcrt_pkg::cmd_t  cmd;
  hcrt_pkg::stat_t stat;

  hcrt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  hcrt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule

>>> src/hcrt_datapath.sv
// Datapath: staging, hashing, chain walk, comparison and insertion memories.
module hcrt_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hcrt_pkg::in_item_t in_item,
  input  hcrt_pkg::cmd_t    cmd,
  output hcrt_pkg::stat_t   stat,
  output hcrt_pkg::out_item_t result,
  output logic              result_strobe
);

  // memories
  logic [63:0]                     stage_mem [hcrt_pkg::MaxRecordWords];
  logic [hcrt_pkg::RecPtrW-1:0]    head_mem  [hcrt_pkg::Buckets];
  logic [hcrt_pkg::RecPtrW-1:0]    next_mem  [hcrt_pkg::Records];
  logic [hcrt_pkg::WordW-1:0]      start_mem [hcrt_pkg::Records];
  logic [hcrt_pkg::LenW-1:0]       len_mem   [hcrt_pkg::Records];
  logic [8:0]                      area_mem  [hcrt_pkg::Records];
  logic [63:0]                     word_mem  [hcrt_pkg::WordCapacity];

  logic [hcrt_pkg::LenW-1:0]     staging_count;
  logic [8:0]                    staging_area;
  logic                          staging_overflow;
  logic                          last_word;
  logic [hcrt_pkg::RecPtrW-1:0]  records_used;
  logic [hcrt_pkg::WordCntW-1:0] words_used;
  logic                          clearing;
  logic [hcrt_pkg::BucketW-1:0]  clear_idx;
  logic                          ins_flag;

  logic [63:0]                   hash;
  logic [hcrt_pkg::LenW-1:0]     idx;
  logic [63:0]                   stage_rd;
  logic [63:0]                   word_rd;
  logic [hcrt_pkg::BucketW-1:0]  bucket;
  logic [hcrt_pkg::RecPtrW-1:0]  head_rd;
  logic [hcrt_pkg::RecPtrW-1:0]  cur;
  logic [hcrt_pkg::RecPtrW-1:0]  prev;
  logic [hcrt_pkg::RecPtrW-1:0]  next_rd;
  logic [hcrt_pkg::WordW-1:0]    start_rd;
  logic [hcrt_pkg::LenW-1:0]     len_rd;
  logic [8:0]                    area_rd;
  logic                          cmp_fail;
  logic                          cmp_pend;
  logic [hcrt_pkg::RecPtrW-1:0]  steps;
  logic [63:0]                   hash_abs;
  logic [hcrt_pkg::WordCntW:0]   words_sum;
  logic [hcrt_pkg::RecW-1:0]     cur_idx;
  logic [hcrt_pkg::WordW-1:0]    addr_rd;

  assign cur_idx = cur[hcrt_pkg::RecW-1:0];

  // stage input words; drop those past the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      staging_count    <= '0;
      staging_area     <= '0;
      staging_overflow <= 1'b0;
      last_word        <= 1'b0;
    end else if (cmd.stage_load) begin
      last_word <= in_item.last_word;
      if (staging_count == '0 && !staging_overflow) staging_area <= in_item.area;
      if (staging_count < hcrt_pkg::LenW'(hcrt_pkg::MaxRecordWords))
        staging_count <= staging_count + 1'b1;
      else
        staging_overflow <= 1'b1;
    end else if (cmd.finish) begin
      staging_count    <= '0;
      staging_overflow <= 1'b0;
      last_word        <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_load && staging_count < hcrt_pkg::LenW'(hcrt_pkg::MaxRecordWords))
      stage_mem[staging_count[hcrt_pkg::StageW-1:0]] <= in_item.word;
  end

  // one staged word read port, addressed by the running index
  always_ff @(posedge clk) begin
    stage_rd <= stage_mem[idx[hcrt_pkg::StageW-1:0]];
  end

  // hash: the read data is registered, so the index runs ahead of it
  always_ff @(posedge clk) begin
    if (cmd.hash_init) begin
      hash <= '0;
      idx  <= '0;
      cmp_pend <= 1'b0;
    end else if (cmd.hash_step) begin
      if (cmp_pend) hash <= (hash << {idx[3:0] - 4'd1, 1'b0}) + stage_rd;
      cmp_pend <= idx < staging_count;
      if (idx < staging_count) idx <= idx + 1'b1;
    end else if (cmd.cmp_init) begin
      idx      <= '0;
      cmp_pend <= 1'b0;
    end else if (cmd.cmp_step || cmd.copy_step) begin
      cmp_pend <= idx < staging_count;
      if (idx < staging_count) idx <= idx + 1'b1;
    end
  end

  assign hash_abs = hash[63] ? (64'd0 - hash) : hash;
  assign bucket   = hash_abs[hcrt_pkg::BucketW-1:0];

  // empty the bucket heads after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == hcrt_pkg::BucketW'(hcrt_pkg::Buckets - 1)) clearing <= 1'b0;
    end
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (clearing) head_mem[clear_idx] <= hcrt_pkg::NullPtr;
    else if (cmd.ins_meta && prev == hcrt_pkg::NullPtr) head_mem[bucket] <= records_used;
    if (cmd.head_read) head_rd <= head_mem[bucket];
  end

  // descriptor memories
  always_ff @(posedge clk) begin
    if (cmd.ins_meta) begin
      start_mem[records_used[hcrt_pkg::RecW-1:0]] <= words_used[hcrt_pkg::WordW-1:0];
      len_mem[records_used[hcrt_pkg::RecW-1:0]]   <= staging_count;
      area_mem[records_used[hcrt_pkg::RecW-1:0]]  <= staging_area;
    end
    if (cmd.meta_read) begin
      start_rd <= start_mem[cur_idx];
      len_rd   <= len_mem[cur_idx];
      area_rd  <= area_mem[cur_idx];
      next_rd  <= next_mem[cur_idx];
    end
  end

  // mark an item whose record is being inserted
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) ins_flag <= 1'b0;
    else if (cmd.ins_meta) ins_flag <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_meta) begin
      next_mem[records_used[hcrt_pkg::RecW-1:0]] <= hcrt_pkg::NullPtr;
    end else if (cmd.finish && ins_flag && prev != hcrt_pkg::NullPtr) begin
      next_mem[prev[hcrt_pkg::RecW-1:0]] <= records_used - 1'b1;
    end
  end

  // chain walk pointers
  always_ff @(posedge clk) begin
    if (cmd.hash_init) begin
      prev  <= hcrt_pkg::NullPtr;
      steps <= '0;
      cur   <= hcrt_pkg::NullPtr;
    end else if (cmd.head_take) begin
      cur <= head_rd;
    end else if (cmd.chain_adv) begin
      prev  <= cur;
      cur   <= next_rd;
      steps <= steps + 1'b1;
    end
  end

  // word store: compare reads, copy writes
  assign addr_rd = start_rd + idx[hcrt_pkg::WordW-1:0];
  always_ff @(posedge clk) begin
    word_rd <= word_mem[addr_rd];
    if (cmd.copy_step && cmp_pend)
      word_mem[words_used[hcrt_pkg::WordW-1:0] + hcrt_pkg::WordW'(idx - 1'b1)] <= stage_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_init) cmp_fail <= 1'b0;
    else if (cmd.cmp_step && cmp_pend && word_rd != stage_rd) cmp_fail <= 1'b1;
  end

  assign words_sum = {1'b0, words_used} + (hcrt_pkg::WordCntW+1)'(staging_count);

  // allocation counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      records_used  <= '0;
      words_used    <= '0;
      result_strobe <= 1'b0;
      result        <= '0;
    end else begin
      result_strobe <= cmd.finish;
      if (cmd.ins_meta) records_used <= records_used + 1'b1;
      if (cmd.finish) begin
        if (staging_overflow) begin
          result <= '{handle: '0, status: hcrt_pkg::ST_TOO_LONG};
        end else if (ins_flag) begin
          result <= '{handle: 12'(records_used - 1'b1), status: hcrt_pkg::ST_INSERTED};
          words_used <= words_sum[hcrt_pkg::WordCntW-1:0];
        end else if (stat.cmp_done && !cmp_fail && stat.meta_match && !stat.chain_end) begin
          result <= '{handle: cur[11:0], status: hcrt_pkg::ST_FOUND};
        end else begin
          result <= '{handle: '0, status: hcrt_pkg::ST_FULL};
        end
      end
    end
  end

  assign stat.last_word  = last_word;
  assign stat.overflow   = staging_overflow;
  assign stat.hash_done  = !cmp_pend && idx >= staging_count;
  assign stat.chain_end  = cur == hcrt_pkg::NullPtr;
  assign stat.meta_match = area_rd == staging_area && len_rd == staging_count
                           && ({1'b0, start_rd} + hcrt_pkg::WordCntW'(len_rd))
                              <= hcrt_pkg::WordCntW'(hcrt_pkg::WordCapacity);
  assign stat.cmp_done   = !cmp_pend && idx >= staging_count;
  assign stat.cmp_fail   = cmp_fail;
  assign stat.full       = records_used >= hcrt_pkg::NullPtr
                           || words_sum > (hcrt_pkg::WordCntW+1)'(hcrt_pkg::WordCapacity);
  assign stat.copy_done  = !cmp_pend && idx >= staging_count;
  assign stat.steps_over = steps > records_used;
  assign stat.clearing   = clearing;

endmodule

>>> src/hcrt_ctrl.sv
// Controller: sequences staging, hash, chain walk, compare and insert.
module hcrt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  hcrt_pkg::stat_t stat,
  output hcrt_pkg::cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CHECK  = 12'b000000000010,
    S_HASH   = 12'b000000000100,
    S_HEAD   = 12'b000000001000,
    S_TAKE   = 12'b000000010000,
    S_META   = 12'b000000100000,
    S_MWAIT  = 12'b000001000000,
    S_CMP    = 12'b000010000000,
    S_NEXT   = 12'b000100000000,
    S_INS    = 12'b001000000000,
    S_COPY   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   found, found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  // hold off input while an item is worked on or the heads are being emptied
  assign busy = state != S_IDLE || stat.clearing;

  // next state and commands
  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.stage_load = start && !stat.clearing;
        if (start && !stat.clearing) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.last_word) state_next = S_IDLE;
        else if (stat.overflow) state_next = S_DONE;
        else begin
          cmd.hash_init = 1'b1;
          found_next    = 1'b0;
          state_next    = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.hash_done) state_next = S_HEAD;
        else cmd.hash_step = 1'b1;
      end
      S_HEAD: begin
        cmd.head_read = 1'b1;
        state_next    = S_TAKE;
      end
      S_TAKE: begin
        cmd.head_take = 1'b1;
        state_next    = S_META;
      end
      S_META: begin
        if (stat.chain_end || stat.steps_over) state_next = S_INS;
        else begin
          cmd.meta_read = 1'b1;
          state_next    = S_MWAIT;
        end
      end
      S_MWAIT: begin
        cmd.cmp_init = 1'b1;
        if (stat.meta_match) state_next = S_CMP;
        else state_next = S_NEXT;
      end
      S_CMP: begin
        if (stat.cmp_fail) state_next = S_NEXT;
        else if (stat.cmp_done) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else cmd.cmp_step = 1'b1;
      end
      S_NEXT: begin
        cmd.chain_adv = 1'b1;
        state_next    = S_META;
      end
      S_INS: begin
        if (stat.full) state_next = S_DONE;
        else begin
          cmd.ins_meta = 1'b1;
          cmd.cmp_init = 1'b1;
          state_next   = S_COPY;
        end
      end
      S_COPY: begin
        if (stat.copy_done) state_next = S_DONE;
        else cmd.copy_step = 1'b1;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a match is only claimed when the compare has not failed
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && state_next == S_DONE) |-> !stat.cmp_fail)
    else $error("match declared after compare failure");
  // a chain step does not go straight to the descriptor wait
  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_NEXT) |=> !(state == S_MWAIT))
    else $error("chain step skipped descriptor read");
  // every finish returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (state == S_IDLE))
    else $error("finish did not return to idle");

endmodule
